// ===== rtl/btc_pkg.sv =====
package btc_pkg;

  // Input item: calendar time fields
  typedef struct packed {
    logic [7:0] year_count;
    logic [8:0] day_of_year;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } time_in_t;

  // Result item: the two header words
  typedef struct packed {
    logic [31:0] time_word;
    logic [31:0] status_word;
  } header_out_t;

  // BCD encoder result: time word and the seconds byte
  typedef struct packed {
    logic [31:0] time_word;
    logic [7:0]  sec_bcd;
  } bcd_fields_t;

  localparam logic [11:0] CrcKey    = 12'h80f;
  localparam logic [31:0] SyncWord  = 32'hffffffff;
  localparam logic [31:0] ZeroWord  = 32'h00000000;

  // Quotient by ten for values below 1024 (reciprocal multiply)
  function automatic logic [6:0] div10(input logic [9:0] x);
    logic [17:0] prod;
    prod = {8'd0, x} * 18'd205;
    return prod[17:11];
  endfunction

  // Low decimal digit of a value below 1024, given its quotient by ten
  function automatic logic [3:0] low_digit(input logic [9:0] x, input logic [6:0] q);
    logic [9:0] rem;
    rem = x - ({3'd0, q} * 10'd10);
    return rem[3:0];
  endfunction

  // Table entry: index in bits 11..4, eight shift steps with conditional key XOR
  function automatic logic [15:0] crc_rom(input logic [7:0] idx);
    logic [19:0] r;
    r = {8'd0, idx, 4'd0};
    for (int k = 0; k < 8; k++) begin
      r = {r[18:0], 1'b0};
      if (r[12]) begin
        r = r ^ {8'd0, CrcKey};
      end
    end
    return r[15:0];
  endfunction

  // Advance the check register over one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    return {crc[7:0], b} ^ crc_rom(crc[11:4]);
  endfunction

  // Advance the check register over one word, most significant byte first
  function automatic logic [15:0] crc_word(input logic [15:0] crc, input logic [31:0] w);
    logic [15:0] r;
    r = crc;
    for (int s = 3; s >= 0; s--) begin
      r = crc_byte(r, w[s*8 +: 8]);
    end
    return r;
  endfunction

  // Check register after the two zero words and the sync word
  localparam logic [15:0] CrcSeed =
    crc_word(crc_word(crc_word(16'h0000, ZeroWord), ZeroWord), SyncWord);

endpackage

// ===== rtl/bcd_timecode_header_crc12_core.sv =====
// Registers in order from input accept to result valid: input, BCD, time-word
// check and result; throughput: one item per cycle while out_ready_i is high.
// The check value runs over the header bytes as table lookups, four per stage.
// Each stage holds while the next one is full, so results stall without loss.
// Reset (rst_ni low, asynchronous) empties all stages; no other state exists.
module bcd_timecode_header_crc12_core
  import btc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  time_in_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output header_out_t out_data_o
);

  logic        v1_q, v2_q, v3_q, v4_q;
  logic        rdy2, rdy3, rdy4;
  time_in_t    in_q;
  bcd_fields_t bcd_d, bcd_q;
  logic [31:0] tw3_q;
  logic [7:0]  sec3_q;
  logic [15:0] crc3_d, crc3_q;
  logic [15:0] crc4_d;
  header_out_t out_d, out_q;

  // Stage moves when empty or when the next stage takes its item
  assign rdy4       = !v4_q || out_ready_i;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign in_ready_o = !v1_q || rdy2;

  // Encode digits
  btc_bcd u_bcd (
    .time_i (in_q),
    .bcd_o  (bcd_d)
  );

  // Check over the time word, from the constant seed
  assign crc3_d = crc_word(CrcSeed, bcd_q.time_word);

  // Check over the status word with zero check bits
  assign crc4_d = crc_word(crc3_q, {sec3_q, 24'h000000});

  assign out_d.time_word   = tw3_q;
  assign out_d.status_word = {sec3_q, 12'h000, crc4_d[11:0]};

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (in_ready_o) v1_q <= in_valid_i;
      if (rdy2)       v2_q <= v1_q;
      if (rdy3)       v3_q <= v2_q;
      if (rdy4)       v4_q <= v3_q;
    end
  end

  // Load payload only where an item moves in
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_q <= in_data_i;
    if (v1_q && rdy2) bcd_q <= bcd_d;
    if (v2_q && rdy3) begin
      tw3_q  <= bcd_q.time_word;
      sec3_q <= bcd_q.sec_bcd;
      crc3_q <= crc3_d;
    end
    if (v3_q && rdy4) out_q <= out_d;
  end

  assign out_valid_o = v4_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_in_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> v1_q)
    else $error("accepted item did not enter the input stage");

  a_s3_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && rdy4) |=> out_valid_o)
    else $error("item lost between check stage and result register");

  a_status_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status_word[23:12] == 12'h000))
    else $error("status word reserved bits not zero");

  a_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.time_word[31:28] <= 4'd9) &&
                     (out_data_o.time_word[3:0] <= 4'd9) &&
                     (out_data_o.time_word[15:12] <= 4'd3)))
    else $error("time word digit out of BCD range");
`endif

endmodule

// ===== rtl/btc_bcd.sv =====
module btc_bcd
  import btc_pkg::*;
(
  input  time_in_t    time_i,
  output bcd_fields_t bcd_o
);

  logic [9:0] day_p1;
  logic [6:0] day_q1;
  logic [6:0] day_q2;
  logic [6:0] year_q;
  logic [6:0] hour_q;
  logic [6:0] min_q;
  logic [6:0] sec_q;
  logic [3:0] day_hund;
  logic [3:0] day_tens;
  logic [3:0] day_units;

  // Day of year is carried one-based
  assign day_p1 = {1'b0, time_i.day_of_year} + 10'd1;

  // Split the day into three digits by repeated division by ten
  assign day_q1    = div10(day_p1);
  assign day_q2    = div10({3'd0, day_q1});
  assign day_units = low_digit(day_p1, day_q1);
  assign day_tens  = low_digit({3'd0, day_q1}, day_q2);
  assign day_hund  = day_q2[3:0];

  assign year_q = div10({2'd0, time_i.year_count});
  assign hour_q = div10({5'd0, time_i.hour});
  assign min_q  = div10({4'd0, time_i.minute});
  assign sec_q  = div10({4'd0, time_i.second});

  // Pack digits, most significant first
  assign bcd_o.time_word = {
    low_digit({2'd0, time_i.year_count}, year_q),
    day_hund, day_tens, day_units,
    hour_q[3:0], low_digit({5'd0, time_i.hour}, hour_q),
    min_q[3:0],  low_digit({4'd0, time_i.minute}, min_q)
  };
  assign bcd_o.sec_bcd = {sec_q[3:0], low_digit({4'd0, time_i.second}, sec_q)};

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import btc_pkg::*;

  localparam logic [11:0] CHECK_KEY = 12'h80f;
  localparam logic [31:0] SYNC_PATTERN = 32'hffffffff;
  localparam logic [31:0] BLANK_WORD = 32'h00000000;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned RANDOM_ITEMS = 1750;
  localparam int unsigned CALM_ITEMS = 250;
  localparam int unsigned REPORT_LIMIT = 10;

  // Predict header words and compare them with what the block returns
  class header_scoreboard;
    header_out_t pending_headers[$];
    int unsigned fields_noted;
    int unsigned headers_checked;
    int unsigned mismatches;

    function new();
      fields_noted = 0;
      headers_checked = 0;
      mismatches = 0;
    endfunction

    // Build one lookup entry: index in bits 11..4, eight shifts with key fold
    function logic [15:0] fold_entry(logic [7:0] idx);
      logic [19:0] r;
      r = {8'd0, idx, 4'd0};
      for (int k = 0; k < 8; k++) begin
        r = r << 1;
        if (r[12]) begin
          r = r ^ {8'd0, CHECK_KEY};
        end
      end
      return r[15:0];
    endfunction

    // Advance the 16-bit check register over a word, high byte first
    function logic [15:0] fold_word(logic [15:0] acc, logic [31:0] w);
      logic [15:0] r;
      r = acc;
      for (int s = 3; s >= 0; s--) begin
        r = {r[7:0], w[s*8 +: 8]} ^ fold_entry(r[11:4]);
      end
      return r;
    endfunction

    function logic [3:0] dec_digit(int unsigned v, int unsigned scale);
      return 4'((v / scale) % 10);
    endfunction

    function header_out_t predict_header(time_in_t t);
      header_out_t h;
      int unsigned day_num;
      logic [15:0] acc;
      day_num = int'(t.day_of_year) + 1;
      h.time_word = {dec_digit(t.year_count, 1), dec_digit(day_num, 100),
                     dec_digit(day_num, 10), dec_digit(day_num, 1),
                     dec_digit(t.hour, 10), dec_digit(t.hour, 1),
                     dec_digit(t.minute, 10), dec_digit(t.minute, 1)};
      h.status_word = {dec_digit(t.second, 10), dec_digit(t.second, 1), 24'd0};
      acc = 16'd0;
      acc = fold_word(acc, BLANK_WORD);
      acc = fold_word(acc, BLANK_WORD);
      acc = fold_word(acc, SYNC_PATTERN);
      acc = fold_word(acc, h.time_word);
      acc = fold_word(acc, h.status_word);
      h.status_word[11:0] = acc[11:0];
      return h;
    endfunction

    function void note_time_fields(time_in_t t);
      pending_headers.push_back(predict_header(t));
      fields_noted++;
    endfunction

    function void check_header(header_out_t seen);
      header_out_t want;
      headers_checked++;
      if (pending_headers.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("unexpected header: time %h status %h",
                   seen.time_word, seen.status_word);
        end
        return;
      end
      want = pending_headers.pop_front();
      if (seen.time_word !== want.time_word || seen.status_word !== want.status_word) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("header %0d: expected time %h status %h, got time %h status %h",
                   headers_checked, want.time_word, want.status_word,
                   seen.time_word, seen.status_word);
        end
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  time_in_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  header_out_t out_data_o;

  bit          idle_on = 1'b1;
  int unsigned cycle_count = 0;
  header_scoreboard sb;

  always #5 clk_i = ~clk_i;

  bcd_timecode_header_crc12_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Watch both handshakes and bound the run
  always @(posedge clk_i) begin
    cycle_count++;
    if (rst_ni && in_valid_i && in_ready_o === 1'b1) begin
      sb.note_time_fields(in_data_i);
    end
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      sb.check_header(out_data_o);
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Stall the result side in short bursts
  initial begin
    forever begin
      @(posedge clk_i);
      if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  function automatic time_in_t make_fields(int unsigned y, int unsigned d, int unsigned h,
                                           int unsigned m, int unsigned s);
    time_in_t f;
    f.year_count = 8'(y);
    f.day_of_year = 9'(d);
    f.hour = 5'(h);
    f.minute = 6'(m);
    f.second = 6'(s);
    return f;
  endfunction

  // Mostly calendar-valid fields, the rest anywhere in the field widths
  function automatic time_in_t random_fields();
    if ($urandom_range(0, 9) < 7) begin
      return make_fields($urandom_range(0, 255), $urandom_range(0, 365),
                         $urandom_range(0, 23), $urandom_range(0, 59),
                         $urandom_range(0, 60));
    end
    return make_fields($urandom_range(0, 255), $urandom_range(0, 511),
                       $urandom_range(0, 31), $urandom_range(0, 63),
                       $urandom_range(0, 63));
  endfunction

  // Offer one item, with an optional gap ahead of it, and hold until taken
  task automatic send_time_fields(input time_in_t fields);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= fields;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
  endtask

  initial begin
    time_in_t directed[$];
    sb = new();
    directed = '{
      make_fields(0, 0, 0, 0, 0),
      make_fields(255, 511, 31, 63, 63),
      make_fields(125, 364, 23, 59, 59),
      make_fields(99, 365, 23, 59, 60),     // leap second, last day of leap year
      make_fields(9, 9, 9, 9, 9),           // day count rolls to two digits
      make_fields(10, 98, 10, 10, 10),
      make_fields(119, 99, 12, 30, 30),     // day count rolls to three digits
      make_fields(123, 499, 20, 50, 10),
      make_fields(1, 255, 1, 1, 1),
      make_fields(2, 256, 2, 2, 2),
      make_fields(170, 0, 24, 60, 61),      // just past the calendar ranges
      make_fields(85, 400, 31, 63, 63),
      make_fields(128, 170, 16, 32, 32),
      make_fields(127, 341, 15, 31, 31),
      make_fields(200, 510, 19, 45, 0)
    };

    // Hold reset, then release it at an edge
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i]) begin
      send_time_fields(directed[i]);
    end
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - CALM_ITEMS) begin
        idle_on <= 1'b0;
      end
      send_time_fields(random_fields());
    end
    in_valid_i <= 1'b0;

    // Drain outstanding headers, then let the pipeline settle
    while (sb.pending_headers.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d time-field items (%0d directed, the rest random, in and out of range).",
             sb.fields_noted, directed.size());
    $display("Checked %0d header pairs with random stalls on both sides; %0d mismatches.",
             sb.headers_checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_headers.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
